### hdl/ttp_pkg.sv
// Shared types, codes and constants for the timed tone PWM player.
// Depends on nothing; the controller, datapath and top level import it.
package ttp_pkg;

    localparam int CLK_W    = 29;   // system clock register width
    localparam int FREQ_W   = 11;   // tone frequency width (max 1047)
    localparam int PROD_W   = 19;   // freq * divider width (max 1047 * 256)
    localparam int DIV_W    = 9;    // clock divider width (1..256)
    localparam int TOP_W    = 16;
    localparam int LEVEL_W  = 15;
    localparam int CNT_W    = 5;    // quotient bit counter (0..CLK_W-1)

    localparam logic [CLK_W-1:0] CLK_HZ_RESET = 29'd125000000;
    localparam logic [TOP_W-1:0] TOP_RESET    = 16'd62499;
    localparam logic [DIV_W-1:0] DIV_RESET    = 9'd1;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_PLAY = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    localparam logic [1:0] TONE_NONE = 2'd0;
    localparam logic [1:0] TONE_HIGH = 2'd1;
    localparam logic [1:0] TONE_MID  = 2'd2;
    localparam logic [1:0] TONE_LOW  = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  tone_select;
        logic [31:0] length_ms;
    } ttp_in_t;

    typedef struct packed {
        logic               amp_standby;
        logic               pwm_enabled;
        logic [DIV_W-1:0]   clock_divider;
        logic [TOP_W-1:0]   period_top;
        logic [LEVEL_W-1:0] duty_level;
        logic [1:0]         tone_active;
    } ttp_out_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic search_step;
        logic div_start;
        logic div_step;
        logic write_out;
    } ttp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic play_req;
        logic search_done;
        logic div_last;
        logic out_free;
    } ttp_status_t;

    function automatic logic [FREQ_W-1:0] tone_freq(input logic [1:0] tone);
        logic [FREQ_W-1:0] f;
        case (tone)
            TONE_HIGH: f = 11'd1047;
            TONE_MID:  f = 11'd523;
            TONE_LOW:  f = 11'd261;
            default:   f = 11'd0;
        endcase
        return f;
    endfunction

endpackage

### hdl/ttp_stream_if.sv
// Valid/ready stream interface carrying one payload struct per transaction.
// Payload type is a parameter; the player uses types from ttp_pkg.
interface ttp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/ttp_controller.sv
// Sequencer for the tone player: accept, divider search and quotient for plays, write.
// Depends on ttp_pkg for the command and status structs.
module ttp_controller
    import ttp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  ttp_status_t status,
    output ttp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DIVIDE = 2'd2;
    localparam logic [1:0] S_WRITE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.play_req ? S_SEARCH : S_WRITE;
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.search_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (status.out_free)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_play_goes_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && status.play_req) |=> (state_reg == S_SEARCH))
        else $error("play transaction did not start the divider search");

    a_plain_goes_to_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !status.play_req) |=> (state_reg == S_WRITE))
        else $error("tick or stop transaction did not go straight to write");

    a_write_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_out |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after write");

endmodule

### hdl/ttp_datapath.sv
// Datapath for the tone player: state registers, divider search,
// bit-serial quotient and result register. Depends on ttp_pkg.
module ttp_datapath
    import ttp_pkg::*;
#(
    parameter int MAX_DIVIDER = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CLK_W-1:0] cfg_wr_data,
    input  ttp_in_t          in_data,
    input  ttp_cmd_t         cmd,
    output ttp_status_t      status,
    output ttp_out_t         out_data,
    output logic             out_valid,
    input  logic             out_ready
);

    logic [CLK_W-1:0]  clk_hz_reg;
    logic [31:0]       now_reg;
    logic [31:0]       end_reg;
    logic [1:0]        tone_reg;
    logic              standby_reg;
    logic [DIV_W-1:0]  divider_reg;
    logic [TOP_W-1:0]  top_reg;
    logic              out_valid_reg;

    logic [FREQ_W-1:0] freq_reg;
    logic [DIV_W-1:0]  sdiv_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [CLK_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    ttp_out_t          out_reg;

    logic [31:0]       now_inc;
    logic              search_more;
    logic [PROD_W:0]   rem_shift;
    logic              fits;
    logic [PROD_W-1:0] rem_next;
    logic [CLK_W-1:0]  quo_next;
    logic [TOP_W-1:0]  top_calc;
    logic              playing;

    assign now_inc = now_reg + 32'd1;

    // Keep raising the divider while clk >= 65536 * freq * div and div < MAX_DIVIDER.
    assign search_more = ((CLK_W + TOP_W)'(clk_hz_reg)
                          >= (CLK_W + TOP_W)'({prod_reg, 16'h0000}))
                       && (sdiv_reg < DIV_W'(MAX_DIVIDER));

    // One quotient bit per step, restoring.
    assign rem_shift = {rem_reg, quo_reg[CLK_W-1]};
    assign fits      = rem_shift >= {1'b0, prod_reg};
    assign rem_next  = fits ? PROD_W'(rem_shift - {1'b0, prod_reg}) : rem_shift[PROD_W-1:0];
    assign quo_next  = {quo_reg[CLK_W-2:0], fits};

    // Clamp the period to 1..65536 counts, then take wrap minus one.
    always_comb
    begin
        if (quo_next > CLK_W'(32'd65536))
        begin
            top_calc = 16'hFFFF;
        end
        else if (quo_next == '0)
        begin
            top_calc = '0;
        end
        else
        begin
            top_calc = TOP_W'(quo_next - CLK_W'(1));
        end
    end

    assign status.play_req    = (in_data.kind == KIND_PLAY) && (in_data.tone_select != TONE_NONE);
    assign status.search_done = !search_more;
    assign status.div_last    = (cnt_reg == '0);
    assign status.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= CLK_HZ_RESET;
            now_reg       <= '0;
            end_reg       <= '0;
            tone_reg      <= TONE_NONE;
            standby_reg   <= 1'b1;
            divider_reg   <= DIV_RESET;
            top_reg       <= TOP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                clk_hz_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                case (in_data.kind)
                    KIND_TICK:
                    begin
                        now_reg <= now_inc;
                        if (tone_reg != TONE_NONE && now_inc >= end_reg)
                        begin
                            standby_reg <= 1'b1;
                            tone_reg    <= TONE_NONE;
                        end
                    end
                    KIND_PLAY:
                    begin
                        if (in_data.tone_select == TONE_NONE)
                        begin
                            standby_reg <= 1'b1;
                            tone_reg    <= TONE_NONE;
                        end
                        else
                        begin
                            standby_reg <= 1'b0;
                            tone_reg    <= in_data.tone_select;
                            end_reg     <= now_reg + in_data.length_ms;
                        end
                    end
                    KIND_STOP:
                    begin
                        standby_reg <= 1'b1;
                        tone_reg    <= TONE_NONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.div_step && status.div_last)
            begin
                divider_reg <= sdiv_reg;
                top_reg     <= top_calc;
            end
            if (cmd.write_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign playing = (tone_reg != TONE_NONE);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg <= tone_freq(in_data.tone_select);
            sdiv_reg <= DIV_W'(1);
            prod_reg <= PROD_W'(tone_freq(in_data.tone_select));
        end
        else if (cmd.search_step && search_more)
        begin
            sdiv_reg <= sdiv_reg + DIV_W'(1);
            prod_reg <= prod_reg + PROD_W'(freq_reg);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= clk_hz_reg;
            cnt_reg <= CNT_W'(CLK_W - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.write_out)
        begin
            out_reg.amp_standby   <= standby_reg;
            out_reg.pwm_enabled   <= playing;
            out_reg.clock_divider <= divider_reg;
            out_reg.period_top    <= top_reg;
            out_reg.duty_level    <= playing ? top_reg[TOP_W-1:1] : '0;
            out_reg.tone_active   <= tone_reg;
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (sdiv_reg >= DIV_W'(1) && sdiv_reg <= DIV_W'(MAX_DIVIDER)))
        else $error("divider search left its range");

    a_divider_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (divider_reg >= DIV_W'(1) && divider_reg <= DIV_W'(MAX_DIVIDER)))
        else $error("programmed divider out of range");

endmodule

### hdl/timed_tone_pwm_player.sv
// Top level of the timed tone PWM player: controller plus datapath.
// Depends on ttp_pkg, ttp_stream_if, ttp_controller and ttp_datapath.
//
//  Channel   Dir   Payload                                   Transaction
//  items     in    kind, tone_select, length_ms              valid & ready
//  results   out   amp_standby, pwm_enabled, clock_divider,  valid & ready
//                  period_top, duty_level, tone_active
//  cfg       in    system_clock_hz (cfg_wr_data)             cfg_wr_en
//
// A tick, stop or unused kind is accepted and its result then written.
// A play of a tone is accepted, then the divider search scans one divider
// per cycle and a restoring divider makes one quotient bit per cycle over
// 29 bits before the write. Reset restores control state at once but not
// the search, quotient or result data; no clearing pass is needed.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits in the write step until the register frees.
module timed_tone_pwm_player
    import ttp_pkg::*;
#(
    parameter int MAX_DIVIDER = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CLK_W-1:0] cfg_wr_data,
    ttp_stream_if.sink       items,
    ttp_stream_if.source     results
);

    ttp_cmd_t    cmd;
    ttp_status_t status;
    ttp_in_t     in_data;
    ttp_out_t    out_data;

    // Hold ready only while the sequencer waits for a new transaction.
    assign items.ready = cmd.in_ready;
    assign in_data     = items.data;
    assign results.data = out_data;

    ttp_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .status   (status),
        .cmd      (cmd)
    );

    ttp_datapath #(
        .MAX_DIVIDER (MAX_DIVIDER)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .status      (status),
        .out_data    (out_data),
        .out_valid   (results.valid),
        .out_ready   (results.ready)
    );

endmodule
